>>> rtl/hm_pkg.sv
// Shared types, widths and codes for the indexed min-heap.
package hm_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned OWNER_W    = 16;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 88;   // position, key, owner
  localparam int unsigned OUT_DATA_W = 120;  // 115 payload bits padded to bytes

  // Parameter defaults
  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned OWNER_BITS_DEF = 16;

  // Operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_OCCUP = 2'd2;

  // One result transaction
  typedef struct packed {
    logic                has_move;
    logic [OWNER_W-1:0]  moved_owner;
    logic [POS_W-1:0]    new_position;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    entry_count;
    logic [KEY_W-1:0]    top_value;
    logic [OWNER_W-1:0]  top_owner;
  } res_t;

endpackage

>>> rtl/hm_mem.sv
// Single write port, single registered read port heap slot memory.
module hm_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/hm_ctrl.sv
// Heap sequencer: slot memory, shared key comparator and sift state machine.
module hm_ctrl #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned OWNER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_kind_i,
  input  logic [7:0]          in_pos_i,
  input  logic [63:0]         in_key_i,
  input  logic [15:0]         in_owner_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output hm_pkg::res_t        res_o
);
  import hm_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned LW   = AW + 2;
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned MW   = KEY_W + OWNER_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LDATA  = 4'd1;
  localparam logic [3:0] S_UP_RD  = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_DN_L   = 4'd4;
  localparam logic [3:0] S_DN_LC  = 4'd5;
  localparam logic [3:0] S_DN_RC  = 4'd6;
  localparam logic [3:0] S_MOVE   = 4'd7;
  localparam logic [3:0] S_PLACE  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         p_q, p_d;
  logic [KEY_W-1:0]      e_key_q, e_key_d;
  logic [OWNER_BITS-1:0] e_own_q, e_own_d;
  logic                  first_q, first_d;
  logic [KEY_W-1:0]      best_key_q, best_key_d;
  logic [OWNER_BITS-1:0] best_own_q, best_own_d;
  logic [AW-1:0]         best_pos_q, best_pos_d;
  logic                  best_sel_q, best_sel_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [KEY_W-1:0]      top_key_q;
  logic [OWNER_BITS-1:0] top_own_q;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [MW-1:0]         mem_wdata, mem_rdata;
  logic [KEY_W-1:0]      rd_key;
  logic [OWNER_BITS-1:0] rd_own;

  logic [AW-1:0]         par;
  logic [LW-1:0]         lchild, rchild, len_ext;
  logic [CMPW-1:0]       pos_ext, cnt_ext;
  logic [KEY_W-1:0]      cmp_a, cmp_b;
  logic                  cmp_lt;
  logic                  fire;

  hm_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_key = mem_rdata[KEY_W-1:0];
  assign rd_own = mem_rdata[KEY_W +: OWNER_BITS];

  // Tree addressing
  assign par     = (p_q - AW'(1)) >> 1;
  assign lchild  = LW'({p_q, 1'b1});
  assign rchild  = lchild + LW'(1);
  assign len_ext = LW'(cnt_q);
  assign pos_ext = CMPW'(in_pos_i);
  assign cnt_ext = CMPW'(cnt_q);

  // Shared 64-bit key comparator: a < b
  assign cmp_a  = (state_q == S_UP_CMP) ? e_key_q : rd_key;
  assign cmp_b  = (state_q == S_UP_CMP) ? rd_key  : best_key_q;
  assign cmp_lt = cmp_a < cmp_b;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire       = res_valid_o & res_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    e_key_d     = e_key_q;
    e_own_d     = e_own_q;
    first_d     = first_q;
    best_key_d  = best_key_q;
    best_own_d  = best_own_q;
    best_pos_d  = best_pos_q;
    best_sel_d  = best_sel_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = p_q;
    mem_wdata   = {e_own_q, e_key_q};
    mem_re      = 1'b0;
    mem_raddr   = par;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          e_key_d  = in_key_i;
          e_own_d  = OWNER_BITS'(in_owner_i);
          first_d  = 1'b1;
          if (in_kind_i == KIND_INSERT) begin
            if (pos_ext < cnt_ext) begin
              p_d     = AW'(in_pos_i);
              state_d = S_UP_RD;
            end else if (cnt_q == CW'(DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              p_d     = AW'(cnt_q);
              cnt_d   = cnt_q + CW'(1);
              state_d = S_UP_RD;
            end
          end else begin
            if (pos_ext >= cnt_ext) begin
              status_d = ST_NOT_OCCUP;
              state_d  = S_FIN;
            end else begin
              cnt_d = cnt_q - CW'(1);
              if (pos_ext < CMPW'(cnt_q - CW'(1))) begin
                // fetch the last entry to fill the hole
                p_d       = AW'(in_pos_i);
                mem_re    = 1'b1;
                mem_raddr = AW'(cnt_q - CW'(1));
                state_d   = S_LDATA;
              end else begin
                state_d = S_FIN;
              end
            end
          end
        end
      end

      S_LDATA: begin
        e_key_d = rd_key;
        e_own_d = rd_own;
        state_d = S_UP_RD;
      end

      S_UP_RD: begin
        if (p_q == '0) begin
          state_d = first_q ? S_DN_L : S_PLACE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = par;
          state_d   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (cmp_lt) begin
          // parent moves down into the current slot
          res_valid_o        = 1'b1;
          res_o.has_move     = 1'b1;
          res_o.moved_owner  = OWNER_W'(rd_own);
          res_o.new_position = POS_W'(p_q);
          mem_we             = fire;
          mem_wdata          = mem_rdata;
          if (fire) begin
            p_d     = par;
            first_d = 1'b0;
            state_d = S_UP_RD;
          end
        end else begin
          state_d = first_q ? S_DN_L : S_PLACE;
        end
      end

      S_DN_L: begin
        best_key_d = e_key_q;
        best_sel_d = 1'b0;
        if (lchild < len_ext) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(lchild);
          state_d   = S_DN_LC;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_DN_LC: begin
        if (cmp_lt) begin
          best_key_d = rd_key;
          best_own_d = rd_own;
          best_pos_d = AW'(lchild);
          best_sel_d = 1'b1;
        end
        if (rchild < len_ext) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rchild);
          state_d   = S_DN_RC;
        end else begin
          state_d = cmp_lt ? S_MOVE : S_PLACE;
        end
      end

      S_DN_RC: begin
        if (cmp_lt) begin
          best_key_d = rd_key;
          best_own_d = rd_own;
          best_pos_d = AW'(rchild);
          best_sel_d = 1'b1;
        end
        state_d = (cmp_lt || best_sel_q) ? S_MOVE : S_PLACE;
      end

      S_MOVE: begin
        // smaller child moves up into the current slot
        res_valid_o        = 1'b1;
        res_o.has_move     = 1'b1;
        res_o.moved_owner  = OWNER_W'(best_own_q);
        res_o.new_position = POS_W'(p_q);
        mem_we             = fire;
        mem_wdata          = {best_own_q, best_key_q};
        if (fire) begin
          p_d     = best_pos_q;
          state_d = S_DN_L;
        end
      end

      S_PLACE: begin
        // final placement of the sifted entry
        res_valid_o        = 1'b1;
        res_o.has_move     = 1'b1;
        res_o.moved_owner  = OWNER_W'(e_own_q);
        res_o.new_position = POS_W'(p_q);
        res_o.last         = 1'b1;
        res_o.status       = status_q;
        res_o.entry_count  = CNT_W'(cnt_q);
        if (p_q == '0) begin
          res_o.top_value = e_key_q;
          res_o.top_owner = OWNER_W'(e_own_q);
        end else begin
          res_o.top_value = top_key_q;
          res_o.top_owner = OWNER_W'(top_own_q);
        end
        mem_we = fire;
        if (fire) begin
          state_d = S_IDLE;
        end
      end

      S_FIN: begin
        res_valid_o       = 1'b1;
        res_o.last        = 1'b1;
        res_o.status      = status_q;
        res_o.entry_count = CNT_W'(cnt_q);
        if (cnt_q != '0) begin
          res_o.top_value = top_key_q;
          res_o.top_owner = OWNER_W'(top_own_q);
        end
        if (fire) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    e_key_q    <= e_key_d;
    e_own_q    <= e_own_d;
    first_q    <= first_d;
    best_key_q <= best_key_d;
    best_own_q <= best_own_d;
    best_pos_q <= best_pos_d;
    best_sel_q <= best_sel_d;
    status_q   <= status_d;
  end

  // Copy of slot zero, tracked on every write there
  always_ff @(posedge clk_i) begin
    if (mem_we && (mem_waddr == '0)) begin
      top_key_q <= mem_wdata[KEY_W-1:0];
      top_own_q <= mem_wdata[KEY_W +: OWNER_BITS];
    end
  end

endmodule

>>> rtl/indexed_min_heap.sv
// Steps: accept, then a parent read and compare per level sifted up, or a read of each child
// and a move per level sifted down, then the final placement; a delete first fetches the last
// entry. An error or a delete of the last slot skips the sift. The pace is set by the single
// read port of the slot memory and the shared 64-bit key comparator, used once per memory read;
// output stalls hold the sequencer. One transaction at a time; results leave through a one-deep
// output register. Reset (async, active low) empties the heap.
module indexed_min_heap #(
  parameter int unsigned DEPTH      = hm_pkg::DEPTH_DEF,
  parameter int unsigned OWNER_BITS = hm_pkg::OWNER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] position, [71:8] key_value, [87:72] owner_id
  input  logic [hm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] moved_owner, [23:16] new_position, [25:24] status, [34:26] entry_count,
  // [98:35] top_value, [114:99] top_owner, [119:115] zero
  output logic [hm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] has_move
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import hm_pkg::*;

  logic res_valid, res_ready;
  res_t res, out_q;
  logic out_v_q;

  hm_ctrl #(
    .DEPTH      (DEPTH),
    .OWNER_BITS (OWNER_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_pos_i    (s_axis_tdata[7:0]),
    .in_key_i    (s_axis_tdata[71:8]),
    .in_owner_i  (s_axis_tdata[87:72]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // Pack result transaction
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.has_move;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'd0, out_q.top_owner, out_q.top_value, out_q.entry_count,
                          out_q.status, out_q.new_position, out_q.moved_owner};

endmodule
